>>> hdl/tls_pkg.sv
package tls_pkg;

  // lifecycle phases, one-hot
  typedef enum logic [4:0] {
    PH_LOST   = 5'b00001,
    PH_DETECT = 5'b00010,
    PH_TRACK  = 5'b00100,
    PH_TEMP   = 5'b01000,
    PH_SWITCH = 5'b10000
  } phase_t;

  // reported track_state codes
  localparam logic [2:0] TS_LOST   = 3'd0;
  localparam logic [2:0] TS_DETECT = 3'd1;
  localparam logic [2:0] TS_TRACK  = 3'd2;
  localparam logic [2:0] TS_TEMP   = 3'd3;
  localparam logic [2:0] TS_SWITCH = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CONFIRM_FRAMES     = 2'd0;
  localparam logic [1:0] CFG_LOSS_LIMIT_NORMAL  = 2'd1;
  localparam logic [1:0] CFG_LOSS_LIMIT_OUTPOST = 2'd2;
  localparam logic [1:0] CFG_GAP_LIMIT_US       = 2'd3;

  localparam int unsigned CFG_DATA_W = 20;

  // register reset values
  localparam logic [7:0]  CONFIRM_FRAMES_RST     = 8'd3;
  localparam logic [9:0]  LOSS_LIMIT_NORMAL_RST  = 10'd15;
  localparam logic [9:0]  LOSS_LIMIT_OUTPOST_RST = 10'd75;
  localparam logic [19:0] GAP_LIMIT_US_RST       = 20'd100000;

  // counter limits
  localparam logic [10:0] SWITCH_MISS_LIMIT = 11'd200;
  localparam logic [7:0]  CONFIRM_MAX       = 8'd255;
  localparam logic [10:0] MISS_MAX          = 11'd2047;

  localparam logic [2:0] PRIORITY_NONE     = 3'd7;
  localparam logic [2:0] PRIORITY_AWAIT_RST = 3'd5;

  typedef struct packed {
    logic [19:0] gap_us;
    logic        main_present;
    logic [2:0]  main_priority;
    logic        main_is_outpost;
    logic        omni_present;
    logic [2:0]  omni_priority;
    logic        target_matched;
    logic        target_converged;
    logic        target_diverged;
    logic        target_bad_fit;
  } in_word_t;

  typedef struct packed {
    logic [2:0] track_state;
    logic       target_valid;
    logic       acquire_target;
    logic       switch_request;
    logic [2:0] switch_priority;
    logic [2:0] target_priority;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  confirm_frames;
    logic [9:0]  loss_limit_normal;
    logic [9:0]  loss_limit_outpost;
    logic [19:0] gap_limit_us;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        prior_switch;
    logic [7:0]  confirm_count;
    logic [10:0] miss_count;
    logic [2:0]  current_priority;
    logic        current_is_outpost;
    logic [2:0]  awaited_priority;
  } track_state_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_LOST:   code = TS_LOST;
      PH_DETECT: code = TS_DETECT;
      PH_TRACK:  code = TS_TRACK;
      PH_TEMP:   code = TS_TEMP;
      PH_SWITCH: code = TS_SWITCH;
      default:   code = TS_LOST;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/tls_update.sv
module tls_update (
  input  tls_pkg::track_state_t state,
  input  tls_pkg::in_word_t     word,
  input  tls_pkg::cfg_t         cfg,
  output tls_pkg::track_state_t state_next,
  output tls_pkg::out_word_t    result
);

  tls_pkg::phase_t ph_mid;
  tls_pkg::phase_t ph_adv;
  tls_pkg::phase_t ph_end;
  logic        found;
  logic        acquire;
  logic        switch_req;
  logic [10:0] miss_inc;
  logic [7:0]  confirm_inc;
  logic [9:0]  loss_limit;

  assign miss_inc    = (state.miss_count != tls_pkg::MISS_MAX) ?
                       state.miss_count + 11'd1 : state.miss_count;
  assign confirm_inc = (state.confirm_count != tls_pkg::CONFIRM_MAX) ?
                       state.confirm_count + 8'd1 : state.confirm_count;

  always_comb begin
    state_next = state;
    found      = 1'b0;
    acquire    = 1'b0;
    switch_req = 1'b0;

    // large gap drops the track before anything else
    ph_mid = state.phase;
    if (state.phase != tls_pkg::PH_LOST && word.gap_us > cfg.gap_limit_us) begin
      ph_mid = tls_pkg::PH_LOST;
    end

    if (ph_mid == tls_pkg::PH_LOST) begin
      acquire = word.main_present;
    end else if (ph_mid == tls_pkg::PH_TRACK && word.main_present &&
                 word.main_priority < state.current_priority) begin
      acquire = 1'b1;
    end else if (ph_mid == tls_pkg::PH_TRACK && word.omni_present &&
                 word.omni_priority < state.current_priority &&
                 word.target_converged) begin
      ph_mid = tls_pkg::PH_SWITCH;
      state_next.awaited_priority = word.omni_priority;
      switch_req = 1'b1;
    end else if (ph_mid == tls_pkg::PH_SWITCH) begin
      found = word.main_present && (word.main_priority == state.awaited_priority);
    end else if (ph_mid == tls_pkg::PH_DETECT && state.prior_switch) begin
      acquire = word.main_present;
    end else begin
      found = word.target_matched;
    end

    if (acquire) begin
      found = 1'b1;
      state_next.current_priority   = word.main_priority;
      state_next.current_is_outpost = word.main_is_outpost;
    end

    state_next.prior_switch = (ph_mid == tls_pkg::PH_SWITCH);
    loss_limit = state_next.current_is_outpost ? cfg.loss_limit_outpost :
                                                 cfg.loss_limit_normal;

    ph_adv = ph_mid;
    unique case (ph_mid)
      tls_pkg::PH_LOST: begin
        if (found) begin
          ph_adv = tls_pkg::PH_DETECT;
          state_next.confirm_count = 8'd1;
        end
      end
      tls_pkg::PH_DETECT: begin
        if (found) begin
          state_next.confirm_count = confirm_inc;
          if (confirm_inc >= cfg.confirm_frames) begin
            ph_adv = tls_pkg::PH_TRACK;
          end
        end else begin
          state_next.confirm_count = 8'd0;
          ph_adv = tls_pkg::PH_LOST;
        end
      end
      tls_pkg::PH_TRACK: begin
        if (!found) begin
          state_next.miss_count = 11'd1;
          ph_adv = tls_pkg::PH_TEMP;
        end
      end
      tls_pkg::PH_SWITCH: begin
        if (found) begin
          ph_adv = tls_pkg::PH_DETECT;
        end else begin
          state_next.miss_count = miss_inc;
          if (miss_inc > tls_pkg::SWITCH_MISS_LIMIT) begin
            ph_adv = tls_pkg::PH_LOST;
          end
        end
      end
      tls_pkg::PH_TEMP: begin
        if (found) begin
          ph_adv = tls_pkg::PH_TRACK;
        end else begin
          state_next.miss_count = miss_inc;
          if (miss_inc > {1'b0, loss_limit}) begin
            ph_adv = tls_pkg::PH_LOST;
          end
        end
      end
      default: ph_adv = tls_pkg::PH_LOST;
    endcase

    // divergence or bad fit kills the track after the update
    ph_end = ph_adv;
    if (ph_adv != tls_pkg::PH_LOST && (word.target_diverged || word.target_bad_fit)) begin
      ph_end = tls_pkg::PH_LOST;
    end
    state_next.phase = ph_end;

    result.track_state     = tls_pkg::phase_code(ph_end);
    result.target_valid    = (ph_end != tls_pkg::PH_LOST);
    result.acquire_target  = acquire;
    result.switch_request  = switch_req;
    result.switch_priority = state_next.awaited_priority;
    result.target_priority = state_next.current_priority;
  end

endmodule

>>> hdl/track_lifecycle_sequencer.sv
// channel  | handshake                    | payload
// ---------+------------------------------+------------------------------
// input    | in_valid / in_ready          | in_word  (tls_pkg::in_word_t)
// output   | out_valid / out_ready        | out_word (tls_pkg::out_word_t)
// config   | cfg_write_en (no wait)       | cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; a word passes the input
// register, the single update step and the result register; the lifecycle state
// register is written together with the result register
// rst is synchronous and active high; it clears phase, counters and both valid
// flags, and sets priorities and config registers to their reset values
// a stalled output holds the result and the input register fills behind it
module track_lifecycle_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tls_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tls_pkg::out_word_t               out_word,
  input  logic                             cfg_write_en,
  input  logic [1:0]                       cfg_index,
  input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // input register
  logic              in_full;
  tls_pkg::in_word_t in_reg;

  // lifecycle state and configuration
  tls_pkg::track_state_t state;
  tls_pkg::track_state_t state_next;
  tls_pkg::cfg_t         cfg;

  tls_pkg::out_word_t result;
  logic               step;

  // a word moves on when the result register is empty or being drained
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  tls_update u_update (
    .state      (state),
    .word       (in_reg),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  // control: valid flags and lifecycle state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full                  <= 1'b0;
      out_valid                <= 1'b0;
      state.phase              <= tls_pkg::PH_LOST;
      state.prior_switch       <= 1'b0;
      state.confirm_count      <= 8'd0;
      state.miss_count         <= 11'd0;
      state.current_priority   <= tls_pkg::PRIORITY_NONE;
      state.current_is_outpost <= 1'b0;
      state.awaited_priority   <= tls_pkg::PRIORITY_AWAIT_RST;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end

      if (step) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_frames     <= tls_pkg::CONFIRM_FRAMES_RST;
      cfg.loss_limit_normal  <= tls_pkg::LOSS_LIMIT_NORMAL_RST;
      cfg.loss_limit_outpost <= tls_pkg::LOSS_LIMIT_OUTPOST_RST;
      cfg.gap_limit_us       <= tls_pkg::GAP_LIMIT_US_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        tls_pkg::CFG_CONFIRM_FRAMES:     cfg.confirm_frames     <= cfg_data[7:0];
        tls_pkg::CFG_LOSS_LIMIT_NORMAL:  cfg.loss_limit_normal  <= cfg_data[9:0];
        tls_pkg::CFG_LOSS_LIMIT_OUTPOST: cfg.loss_limit_outpost <= cfg_data[9:0];
        tls_pkg::CFG_GAP_LIMIT_US:       cfg.gap_limit_us       <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_word;
    end
    if (step) begin
      out_word <= result;
    end
  end

`ifndef SYNTHESIS
  // a refused input only ever means the input register is occupied
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> in_full)
    else $error("input refused while input register empty");

  // a held word in the input register does not change while it waits
  assert property (@(posedge clk) disable iff (rst)
    in_full && !step |=> in_full && $stable(in_reg))
    else $error("waiting input word lost or altered");

  // a switch request leaves the track switching or dropped
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.switch_request |->
      (out_word.track_state == tls_pkg::TS_SWITCH ||
       out_word.track_state == tls_pkg::TS_LOST))
    else $error("switch request with wrong track state");

  // the awaited omni target always outranks the current one on a request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.switch_request |->
      out_word.switch_priority < out_word.target_priority)
    else $error("switch toward a target of no higher priority");
`endif

endmodule

>>> verif/track_lifecycle_sequencer_test.sv
module track_lifecycle_sequencer_test;
  import tls_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // dut ports; the ones driven here are known from time zero
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_write_en = 1'b0;
  logic [1:0]            cfg_index = CFG_CONFIRM_FRAMES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  track_lifecycle_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // words waiting to be sent, and results still owed by the block
  in_word_t  frame_q[$];
  out_word_t owed_q[$];
  int        frames_queued = 0;
  int        frames_taken = 0;
  logic      broken = 1'b0;
  // set for the last part of the run: no idling on either side
  logic      no_idle = 1'b0;

  // our copy of the registers, kept in step with every write
  logic [7:0]  cf_confirm = CONFIRM_FRAMES_RST;
  logic [9:0]  cf_loss_norm = LOSS_LIMIT_NORMAL_RST;
  logic [9:0]  cf_loss_out = LOSS_LIMIT_OUTPOST_RST;
  logic [19:0] cf_gap = GAP_LIMIT_US_RST;

  // lifecycle state as the block should hold it
  phase_t      trk_phase = PH_LOST;
  phase_t      trk_prior = PH_LOST;
  logic [7:0]  confirm_cnt = '0;
  logic [10:0] miss_cnt = '0;
  logic [2:0]  cur_pri = PRIORITY_NONE;
  logic        cur_outpost = 1'b0;
  logic [2:0]  await_pri = PRIORITY_AWAIT_RST;

  // one frame through the lifecycle; returns the result word it should produce
  function automatic out_word_t track_frame(input in_word_t w);
    logic       found;
    logic       acq;
    logic       sw;
    logic [9:0] lim;
    out_word_t  r;
    found = 1'b0;
    acq = 1'b0;
    sw = 1'b0;
    // a long frame gap kills the track before anything else
    if (trk_phase != PH_LOST && w.gap_us > cf_gap) trk_phase = PH_LOST;

    if (trk_phase == PH_LOST) begin
      acq = w.main_present;
    end else if (trk_phase == PH_TRACK && w.main_present && w.main_priority < cur_pri) begin
      // better main armor in view: take it over
      acq = 1'b1;
    end else if (trk_phase == PH_TRACK && w.omni_present && w.omni_priority < cur_pri &&
                 w.target_converged) begin
      trk_phase = PH_SWITCH;
      await_pri = w.omni_priority;
      sw = 1'b1;
    end else if (trk_phase == PH_SWITCH) begin
      found = w.main_present && (w.main_priority == await_pri);
    end else if (trk_phase == PH_DETECT && trk_prior == PH_SWITCH) begin
      // first frame after a switch picks up the main armor afresh
      acq = w.main_present;
    end else begin
      found = w.target_matched;
    end

    if (acq) begin
      found = 1'b1;
      cur_pri = w.main_priority;
      cur_outpost = w.main_is_outpost;
    end

    trk_prior = trk_phase;
    case (trk_phase)
      PH_LOST: begin
        if (found) begin
          trk_phase = PH_DETECT;
          confirm_cnt = 8'd1;
        end
      end
      PH_DETECT: begin
        if (found) begin
          if (confirm_cnt != CONFIRM_MAX) confirm_cnt = confirm_cnt + 8'd1;
          if (confirm_cnt >= cf_confirm) trk_phase = PH_TRACK;
        end else begin
          confirm_cnt = '0;
          trk_phase = PH_LOST;
        end
      end
      PH_TRACK: begin
        if (!found) begin
          miss_cnt = 11'd1;
          trk_phase = PH_TEMP;
        end
      end
      PH_SWITCH: begin
        // miss count carries on from wherever it was
        if (found) begin
          trk_phase = PH_DETECT;
        end else begin
          if (miss_cnt != MISS_MAX) miss_cnt = miss_cnt + 11'd1;
          if (miss_cnt > SWITCH_MISS_LIMIT) trk_phase = PH_LOST;
        end
      end
      PH_TEMP: begin
        if (found) begin
          trk_phase = PH_TRACK;
        end else begin
          lim = cur_outpost ? cf_loss_out : cf_loss_norm;
          if (miss_cnt != MISS_MAX) miss_cnt = miss_cnt + 11'd1;
          if (miss_cnt > {1'b0, lim}) trk_phase = PH_LOST;
        end
      end
      default: trk_phase = PH_LOST;
    endcase

    // divergence or a bad fit drops the track after the update
    if (trk_phase != PH_LOST && (w.target_diverged || w.target_bad_fit)) trk_phase = PH_LOST;

    case (trk_phase)
      PH_DETECT: r.track_state = TS_DETECT;
      PH_TRACK:  r.track_state = TS_TRACK;
      PH_TEMP:   r.track_state = TS_TEMP;
      PH_SWITCH: r.track_state = TS_SWITCH;
      default:   r.track_state = TS_LOST;
    endcase
    r.target_valid = (trk_phase != PH_LOST);
    r.acquire_target = acq;
    r.switch_request = sw;
    r.switch_priority = await_pri;
    r.target_priority = cur_pri;
    return r;
  endfunction

  // sender: holds each word until taken, and now and then idles between words
  logic [3:0] send_hold = '0;

  always @(posedge clk) begin : frame_sender
    logic     next_valid;
    in_word_t next_word;
    if (rst) begin
      in_valid <= 1'b0;
      send_hold <= '0;
    end else begin
      next_valid = in_valid;
      next_word = in_word;
      if (in_valid && in_ready) begin
        owed_q = {owed_q, track_frame(in_word)};
        frames_taken = frames_taken + 1;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_hold != 0) begin
          send_hold <= send_hold - 4'd1;
        end else if (frame_q.size() != 0) begin
          if (!no_idle && $urandom_range(0, 7) == 0) begin
            send_hold <= 4'($urandom_range(0, 14));
          end else begin
            next_word = frame_q.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
      in_word <= next_word;
    end
  end

  task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      broken = 1'b1;
    end
  endtask

  // receiver: checks every result word against the oldest one owed
  logic [3:0] stall_left = '0;

  always @(posedge clk) begin : result_watch
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: result expected none got %h", $time, out_word);
          broken = 1'b1;
        end else begin
          want = owed_q.pop_front();
          check_field("track_state", want.track_state, out_word.track_state);
          check_field("target_valid", 3'(want.target_valid), 3'(out_word.target_valid));
          check_field("acquire_target", 3'(want.acquire_target), 3'(out_word.acquire_target));
          check_field("switch_request", 3'(want.switch_request), 3'(out_word.switch_request));
          check_field("switch_priority", want.switch_priority, out_word.switch_priority);
          check_field("target_priority", want.target_priority, out_word.target_priority);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 4'd1;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left <= 4'($urandom_range(0, 14));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_word(input in_word_t w);
    frame_q = {frame_q, w};
    frames_queued = frames_queued + 1;
  endtask

  function automatic in_word_t frame_of(input logic [19:0] gap, input logic mp,
                                         input logic [2:0] mpri, input logic mout,
                                         input logic op, input logic [2:0] opri,
                                         input logic mat, input logic conv,
                                         input logic dv, input logic bfit);
    in_word_t w;
    w.gap_us = gap;
    w.main_present = mp;
    w.main_priority = mpri;
    w.main_is_outpost = mout;
    w.omni_present = op;
    w.omni_priority = opri;
    w.target_matched = mat;
    w.target_converged = conv;
    w.target_diverged = dv;
    w.target_bad_fit = bfit;
    return w;
  endfunction

  function automatic in_word_t noise_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  // plausible frame: gap within limit, sane priorities, rare drop flags
  function automatic in_word_t steady_word(input logic matched);
    in_word_t w;
    w = noise_word();
    w.gap_us = (cf_gap == 0) ? 20'd0 : 20'($urandom_range(0, cf_gap));
    if ($urandom_range(0, 7) != 0) w.main_priority = 3'($urandom_range(1, 5));
    if ($urandom_range(0, 7) != 0) w.omni_priority = 3'($urandom_range(1, 5));
    w.main_present = ($urandom_range(0, 2) == 0);
    w.omni_present = ($urandom_range(0, 3) == 0);
    w.target_matched = matched;
    w.target_diverged = ($urandom_range(0, 39) == 0);
    w.target_bad_fit = ($urandom_range(0, 39) == 0);
    return w;
  endfunction

  // force a clean acquire, confirm it, switch, then starve the switch until it drops
  task automatic add_switch_timeout();
    in_word_t w;
    int       k;
    w = steady_word(1'b0);
    w.main_present = 1'b0;
    w.target_diverged = 1'b1;
    add_word(w);
    w = steady_word(1'b1);
    w.main_present = 1'b1;
    w.main_priority = 3'd3;
    w.target_diverged = 1'b0;
    w.target_bad_fit = 1'b0;
    add_word(w);
    for (k = 0; k <= cf_confirm; k++) begin
      w = steady_word(1'b1);
      w.main_present = 1'b0;
      w.omni_present = 1'b0;
      w.target_diverged = 1'b0;
      w.target_bad_fit = 1'b0;
      add_word(w);
    end
    w.omni_present = 1'b1;
    w.omni_priority = 3'd1;
    w.target_converged = 1'b1;
    add_word(w);
    for (k = 0; k < 205; k++) begin
      w = steady_word(1'($urandom));
      w.main_priority = 3'd3;
      w.target_diverged = 1'b0;
      w.target_bad_fit = 1'b0;
      add_word(w);
    end
  endtask

  // random part built from runs: holds, misses, switch attempts, acquires, noise
  task automatic add_random(input int n);
    int        added;
    int        len;
    int        k;
    logic [2:0] p;
    in_word_t  w;
    added = 0;
    while (added < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 20);
          for (k = 0; k < len; k++) add_word(steady_word(1'b1));
        end
        4, 5: begin
          len = $urandom_range(1, 80);
          for (k = 0; k < len; k++) begin
            w = steady_word(1'b0);
            w.main_present = ($urandom_range(0, 5) == 0);
            w.omni_present = 1'b0;
            add_word(w);
          end
        end
        6: begin
          p = 3'($urandom_range(0, 4));
          len = $urandom_range(1, 3);
          for (k = 0; k < len; k++) begin
            w = steady_word(1'b1);
            w.main_present = 1'b0;
            w.omni_present = 1'b1;
            w.omni_priority = p;
            w.target_converged = 1'b1;
            add_word(w);
          end
          added = added + len;
          len = len + $urandom_range(1, 6);
          for (k = 0; k < len; k++) begin
            w = steady_word(1'($urandom));
            w.main_present = 1'b1;
            if ($urandom_range(0, 2) != 0) w.main_priority = p;
            add_word(w);
          end
        end
        7: begin
          len = $urandom_range(1, 5);
          for (k = 0; k < len; k++) add_word(noise_word());
        end
        default: begin
          w = steady_word(1'b1);
          w.main_present = 1'b1;
          add_word(w);
          len = (cf_confirm > 28) ? 30 : cf_confirm + 2;
          len = $urandom_range(1, len);
          for (k = 0; k < len; k++) add_word(steady_word(1'b1));
          len = len + 1;
        end
      endcase
      added = added + len;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_CONFIRM_FRAMES:     cf_confirm = val[7:0];
      CFG_LOSS_LIMIT_NORMAL:  cf_loss_norm = val[9:0];
      CFG_LOSS_LIMIT_OUTPOST: cf_loss_out = val[9:0];
      default:                cf_gap = val[19:0];
    endcase
  endtask

  task automatic write_all(input logic [7:0] conf, input logic [9:0] norm,
                           input logic [9:0] outp, input logic [19:0] gap);
    write_reg(CFG_CONFIRM_FRAMES, CFG_DATA_W'(conf));
    write_reg(CFG_LOSS_LIMIT_NORMAL, CFG_DATA_W'(norm));
    write_reg(CFG_LOSS_LIMIT_OUTPOST, CFG_DATA_W'(outp));
    write_reg(CFG_GAP_LIMIT_US, gap);
  endtask

  // sampled on the falling edge so the counters are settled
  task automatic drain();
    while (frames_taken != frames_queued || owed_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed frames at reset settings
    add_word(frame_of(20'd0, 0, 3'd0, 0, 0, 3'd0, 0, 0, 0, 0));       // nothing seen
    add_word(frame_of(20'd10, 1, 3'd7, 1, 0, 3'd0, 0, 0, 0, 0));      // acquire odd priority
    add_word(frame_of(20'd10, 0, 3'd0, 0, 0, 3'd0, 1, 0, 0, 0));
    add_word(frame_of(20'd10, 0, 3'd0, 0, 0, 3'd0, 1, 0, 0, 0));      // confirmed
    add_word(frame_of(20'd10, 1, 3'd4, 0, 0, 3'd0, 1, 0, 0, 0));      // takeover
    add_word(frame_of(20'd10, 0, 3'd0, 0, 1, 3'd2, 1, 0, 0, 0));      // omni, not converged
    add_word(frame_of(20'd10, 0, 3'd0, 0, 1, 3'd2, 1, 1, 0, 0));      // switch
    add_word(frame_of(20'd10, 1, 3'd3, 0, 0, 3'd0, 1, 0, 0, 0));      // wrong armor
    add_word(frame_of(20'd10, 1, 3'd2, 0, 0, 3'd0, 0, 0, 0, 0));      // switch done
    add_word(frame_of(20'd10, 1, 3'd5, 1, 0, 3'd0, 0, 0, 0, 0));      // reacquire after switch
    add_word(frame_of(20'd10, 0, 3'd0, 0, 0, 3'd0, 0, 0, 0, 0));      // temp lost
    add_word(frame_of(20'd10, 0, 3'd0, 0, 0, 3'd0, 1, 0, 0, 0));      // back to tracking
    add_word(frame_of(20'd100001, 1, 3'd1, 0, 0, 3'd0, 1, 0, 0, 0));  // gap just over limit
    add_word(frame_of(20'd100000, 0, 3'd0, 0, 0, 3'd0, 1, 0, 0, 0));  // gap at limit
    add_word(frame_of(20'd0, 0, 3'd0, 0, 0, 3'd0, 1, 0, 1, 0));       // diverged
    add_word(frame_of(20'd0, 1, 3'd6, 0, 0, 3'd0, 0, 0, 0, 0));
    add_word(frame_of(20'd0, 0, 3'd0, 0, 0, 3'd0, 1, 0, 0, 1));       // bad fit
    add_word(frame_of(20'hFFFFF, 0, 3'd0, 0, 0, 3'd0, 0, 0, 0, 0));   // gap ignored when lost
    add_word(frame_of(20'hFFFFF, 1, 3'd7, 1, 1, 3'd7, 1, 1, 1, 1));   // everything set
    add_random(130);
    drain();

    // low extremes: any nonzero gap drops, no loss allowed
    write_all(8'd1, 10'd0, 10'd0, 20'd0);
    add_switch_timeout();
    add_random(130);
    drain();

    // high extremes
    write_all(8'd255, 10'd1023, 10'd1023, 20'hFFFFF);
    add_random(130);
    drain();

    // confirm of zero, short loss limits
    write_all(8'd0, 10'($urandom_range(1, 8)), 10'($urandom_range(10, 30)),
              20'($urandom_range(50000, 200000)));
    add_random(130);
    drain();

    write_all(8'($urandom_range(1, 6)), 10'($urandom_range(0, 40)),
              10'($urandom_range(0, 90)), 20'($urandom));
    add_random(130);
    drain();

    // last stretch at full rate
    no_idle = 1'b1;
    write_all(8'd2, 10'd5, 10'd40, 20'd100000);
    add_switch_timeout();
    add_random(130);
    drain();

    if (!broken) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
hdl/tls_pkg.sv
hdl/tls_update.sv
hdl/track_lifecycle_sequencer.sv
verif/track_lifecycle_sequencer_test.sv
